// ----- rtl/spherocylinder_drag_coefficients_top_macros.svh -----
`ifndef SPHEROCYLINDER_DRAG_COEFFICIENTS_TOP_MACROS_SVH
`define SPHEROCYLINDER_DRAG_COEFFICIENTS_TOP_MACROS_SVH
// checks on clk, held off while arst_n is low
`define SDC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/sdc_pkg.sv -----
`timescale 1ns / 1ps
package sdc_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_W = 48;
	localparam int LOG_STEPS = 30;
	localparam int EXP_W = 5;
	localparam int LOG_W = EXP_W + LOG_STEPS;
	localparam int Y_W = 34;
	localparam int X1_W = 37;
	localparam int PI_W = 34;
	localparam int B_W = 36;
	localparam int D_W = 39;
	localparam int ADDR_W = 3;
	localparam logic [PI_W-1:0] PI_Q32 = 34'h3_243F_6A89;
	localparam logic [X1_W-1:0] PI6_Q32 = 37'd6 * X1_W'(PI_Q32);
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
	localparam logic REG_VISCOSITY = 1'b0;

	typedef logic [OUT_W-1:0] quot_t;
	typedef logic [D_W-1:0] dvsr_t;
	localparam quot_t OUT_MAX = '1;
endpackage

// ----- rtl/spherocylinder_drag_coefficients_top.sv -----
// Drag coefficients of a sphero-cylinder: one request of radius and length (unsigned
// fixed point, FRAC_BITS fraction bits) in, three drag coefficients plus sphere, saturation
// and invalid flags out. A new request is taken every clock while the pipeline is not
// held; each result passes the 30-step base-2 logarithm chain and the 48-cell restoring
// divider behind it before it reaches the output register. The pipeline only holds when
// its last stage and the output register are both full and not taken. Write viscosity
// only while no request is in flight.
`timescale 1ns / 1ps
`include "spherocylinder_drag_coefficients_top_macros.svh"
module spherocylinder_drag_coefficients_top #(
	parameter int FRAC_BITS = sdc_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,  // radius, body_length
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [143:0]               m_tdata,  // drag_parallel, drag_perpendicular, drag_rotation
	output logic [2:0]                 m_tuser,  // sphere_mode, saturated, invalid
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sdc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	localparam int OW = sdc_pkg::OUT_W;
	localparam int DW = sdc_pkg::D_W;
	localparam int EW = sdc_pkg::EXP_W;
	localparam int LW = sdc_pkg::LOG_W;
	localparam int YW = sdc_pkg::Y_W;
	localparam int XW = sdc_pkg::X1_W;
	localparam int BW = sdc_pkg::B_W;
	localparam int NSTEP = sdc_pkg::LOG_STEPS;
	localparam int S_LOG0 = 2;
	localparam int S_LOGE = S_LOG0 + 2 * NSTEP;
	localparam int S_BP = S_LOGE + 3;
	localparam int S_B = S_BP + 1;
	localparam int S_M1 = S_B - 8;
	localparam int S_DIV0 = S_B + 2;
	localparam int LAT = S_DIV0 + OW;
	localparam int PA_W = XW + YW + 32;
	localparam int RC_W = 3 * YW + sdc_pkg::PI_W + 32;
	localparam int NA_W = PA_W + 1;
	localparam int NB_W = PA_W + 2;
	localparam int NC_W = RC_W + 1;
	localparam int KA_S = 33 + FRAC_BITS;
	localparam int KA_L = FRAC_BITS;
	localparam int KC_S = 3 * FRAC_BITS + 32;
	localparam int KC_L = 3 * FRAC_BITS + 1;

	function automatic logic [EW-1:0] msb_pos(input logic [31:0] x);
		logic [EW-1:0] p;
		p = '0;
		for (int i = 1; i < 32; i++) begin
			if (x[i]) begin
				p = EW'(i);
			end
		end
		return p;
	endfunction

	// configuration
	logic [31:0] visc_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite && (paddr[sdc_pkg::ADDR_W-1] == sdc_pkg::REG_VISCOSITY);
	assign prdata = (paddr[sdc_pkg::ADDR_W-1] == sdc_pkg::REG_VISCOSITY) ? visc_q : '0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_q <= 32'd1 << FRAC_BITS;
		end else if (cfg_wr) begin
			visc_q <= pwdata;
		end
	end

	// pipeline control
	logic [LAT-1:0] vld_q;
	logic           en;
	logic           m_tvalid_q;
	logic [143:0]   m_tdata_q;
	logic [2:0]     m_tuser_q;

	assign en = !(vld_q[LAT-1] && m_tvalid_q && !m_tready);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: capture
	logic [31:0] r_s1;
	logic [31:0] len_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= s_tdata[31:0];
			len_s1 <= s_tdata[63:32];
		end
	end

	// stage 2: mode, operands, log normalisation
	logic          sph_c;
	logic [YW-1:0] rad2_c;
	logic [EW-1:0] el_c;
	logic [EW-1:0] er_c;
	logic          sph_s2;
	logic          inv_s2;
	logic [YW-1:0] y_s2;
	logic [XW-1:0] x1_s2;
	logic [EW-1:0] el_s2;
	logic [EW-1:0] er_s2;
	logic [63:0]   ml_s2;
	logic [63:0]   mr_s2;

	always_comb begin
		sph_c  = {1'b0, len_s1} < {r_s1, 1'b0};
		rad2_c = {2'b0, len_s1} + {1'b0, r_s1, 1'b0};
		el_c   = msb_pos(len_s1);
		er_c   = msb_pos(r_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sph_s2 <= sph_c;
			inv_s2 <= r_s1 == '0;
			y_s2   <= sph_c ? rad2_c : {2'b0, len_s1};
			x1_s2  <= sph_c ? sdc_pkg::PI6_Q32 : XW'(sdc_pkg::PI_Q32);
			el_s2  <= el_c;
			er_s2  <= er_c;
			ml_s2  <= 64'(len_s1) << (6'd62 - 6'(el_c));
			mr_s2  <= 64'(r_s1) << (6'd62 - 6'(er_c));
		end
	end

	// logarithm chains
	logic [63:0]      ml_c [NSTEP+1];
	logic [63:0]      mr_c [NSTEP+1];
	logic [NSTEP-1:0] fl_c [NSTEP+1];
	logic [NSTEP-1:0] fr_c [NSTEP+1];

	assign ml_c[0] = ml_s2;
	assign mr_c[0] = mr_s2;
	assign fl_c[0] = '0;
	assign fr_c[0] = '0;

	for (genvar i = 0; i < NSTEP; i++) begin : g_log
		sdc_log_cell u_log_l (
			.clk (clk), .en (en),
			.m_i (ml_c[i]), .f_i (fl_c[i]), .m_o (ml_c[i+1]), .f_o (fl_c[i+1])
		);
		sdc_log_cell u_log_r (
			.clk (clk), .en (en),
			.m_i (mr_c[i]), .f_i (fr_c[i]), .m_o (mr_c[i+1]), .f_o (fr_c[i+1])
		);
	end

	logic [2*EW-1:0] e_d;
	logic [LW-1:0]   d_s63;
	logic [LW+31:0]  bp;

	sdc_delay #(.W(2*EW), .DEPTH(S_LOGE - S_LOG0)) u_e_dly (
		.clk (clk), .en (en), .d ({el_s2, er_s2}), .q (e_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s63 <= {e_d[2*EW-1:EW], fl_c[NSTEP]} - {e_d[EW-1:0], fr_c[NSTEP]};
		end
	end

	sdc_mul #(.WA(LW), .WB(32)) u_bmul (
		.clk (clk), .en (en), .a (d_s63), .b (sdc_pkg::LN2_Q32), .p (bp)
	);

	// b = 2 ln(L/R) - 1 in Q.30
	logic [1:0]      fl_bp;
	logic [LW+32:0]  br;
	logic [BW-1:0]   b30;
	logic [BW:0]     bp2;
	logic [DW-1:0]   b3;
	logic            sph_s66;
	logic            inv_s66;
	sdc_pkg::dvsr_t  da_s66;
	sdc_pkg::dvsr_t  db_s66;
	sdc_pkg::dvsr_t  dc_s66;

	sdc_delay #(.W(2), .DEPTH(S_BP - S_LOG0)) u_fl_dly (
		.clk (clk), .en (en), .d ({sph_s2, inv_s2}), .q (fl_bp)
	);

	always_comb begin
		br  = (LW+33)'(bp) + ((LW+33)'(1) << 30);
		b30 = br[31 +: BW] - (BW'(1) << 30);
		bp2 = (BW+1)'(b30) + ((BW+1)'(1) << 31);
		b3  = DW'(bp2) + (DW'(bp2) << 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sph_s66 <= fl_bp[1];
			inv_s66 <= fl_bp[0];
			da_s66  <= fl_bp[1] ? DW'(1) : DW'(b30);
			db_s66  <= fl_bp[1] ? DW'(1) : DW'(bp2);
			dc_s66  <= fl_bp[1] ? DW'(1) : b3;
		end
	end

	// numerators: y = rad2 or L; x1 = 6 pi or pi
	logic [YW-1:0]        y_m1;
	logic [XW-1:0]        x1_m1;
	logic [YW-1:0]        y_m2;
	logic [2*YW-1:0]      y2;
	logic [XW+YW-1:0]     ax;
	logic [3*YW-1:0]      y3;
	logic [PA_W-1:0]      pa;
	logic [PA_W-1:0]      pa_s66;
	logic [RC_W-32-1:0]   qc;
	logic [RC_W-1:0]      rc_s66;

	sdc_delay #(.W(YW + XW), .DEPTH(S_M1 - S_LOG0)) u_y_dly (
		.clk (clk), .en (en), .d ({y_s2, x1_s2}), .q ({y_m1, x1_m1})
	);
	sdc_delay #(.W(YW), .DEPTH(2)) u_y2_dly (
		.clk (clk), .en (en), .d (y_m1), .q (y_m2)
	);
	sdc_mul #(.WA(YW), .WB(YW)) u_m_yy (
		.clk (clk), .en (en), .a (y_m1), .b (y_m1), .p (y2)
	);
	sdc_mul #(.WA(XW), .WB(YW)) u_m_xy (
		.clk (clk), .en (en), .a (x1_m1), .b (y_m1), .p (ax)
	);
	sdc_mul #(.WA(2*YW), .WB(YW)) u_m_yyy (
		.clk (clk), .en (en), .a (y2), .b (y_m2), .p (y3)
	);
	sdc_mul #(.WA(XW+YW), .WB(32)) u_m_pa (
		.clk (clk), .en (en), .a (ax), .b (visc_q), .p (pa)
	);
	sdc_mul #(.WA(3*YW), .WB(sdc_pkg::PI_W)) u_m_pi (
		.clk (clk), .en (en), .a (y3), .b (sdc_pkg::PI_Q32), .p (qc)
	);
	sdc_mul #(.WA(RC_W-32), .WB(32)) u_m_rc (
		.clk (clk), .en (en), .a (qc), .b (visc_q), .p (rc_s66)
	);
	sdc_delay #(.W(PA_W), .DEPTH(S_B - (S_M1 + 4))) u_pa_dly (
		.clk (clk), .en (en), .d (pa), .q (pa_s66)
	);

	// rounding offset and power-of-two part of the denominator
	logic [NA_W-1:0] na;
	logic [NB_W-1:0] nb;
	logic [NC_W-1:0] nc;
	logic [NA_W-1:0] nqa_s67;
	logic [NB_W-1:0] nqb_s67;
	logic [NC_W-1:0] nqc_s67;
	sdc_pkg::dvsr_t  da_s67;
	sdc_pkg::dvsr_t  db_s67;
	sdc_pkg::dvsr_t  dc_s67;
	logic            sph_s67;
	logic            inv_s67;

	always_comb begin
		na = NA_W'(pa_s66) + (sph_s66 ? (NA_W'(da_s66) << (KA_S - 1))
		                              : (NA_W'(da_s66) << (KA_L - 1)));
		nb = (sph_s66 ? NB_W'(pa_s66) : (NB_W'(pa_s66) << 1))
		   + (sph_s66 ? (NB_W'(db_s66) << (KA_S - 1)) : (NB_W'(db_s66) << (KA_L - 1)));
		nc = NC_W'(rc_s66) + (sph_s66 ? (NC_W'(dc_s66) << (KC_S - 1))
		                              : (NC_W'(dc_s66) << (KC_L - 1)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nqa_s67 <= sph_s66 ? (na >> KA_S) : (na >> KA_L);
			nqb_s67 <= sph_s66 ? (nb >> KA_S) : (nb >> KA_L);
			nqc_s67 <= sph_s66 ? (nc >> KC_S) : (nc >> KC_L);
			da_s67  <= da_s66;
			db_s67  <= db_s66;
			dc_s67  <= dc_s66;
			sph_s67 <= sph_s66;
			inv_s67 <= inv_s66;
		end
	end

	// overflow check and divider seed
	logic [NA_W-1:0] hia;
	logic [NB_W-1:0] hib;
	logic [NC_W-1:0] hic;
	sdc_pkg::dvsr_t  rem_s68 [3];
	sdc_pkg::quot_t  t_s68 [3];
	sdc_pkg::dvsr_t  d_s68 [3];
	logic [2:0]      sat_s68;
	logic            sph_s68;
	logic            inv_s68;

	always_comb begin
		hia = nqa_s67 >> OW;
		hib = nqb_s67 >> OW;
		hic = nqc_s67 >> OW;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s68    <= {hic >= NC_W'(dc_s67), hib >= NB_W'(db_s67), hia >= NA_W'(da_s67)};
			rem_s68[0] <= hia[DW-1:0];
			rem_s68[1] <= hib[DW-1:0];
			rem_s68[2] <= hic[DW-1:0];
			t_s68[0]   <= nqa_s67[OW-1:0];
			t_s68[1]   <= nqb_s67[OW-1:0];
			t_s68[2]   <= nqc_s67[OW-1:0];
			d_s68[0]   <= da_s67;
			d_s68[1]   <= db_s67;
			d_s68[2]   <= dc_s67;
			sph_s68    <= sph_s67;
			inv_s68    <= inv_s67;
		end
	end

	// divider rows, one quotient bit per cell
	sdc_pkg::dvsr_t rem_c [3][OW+1];
	sdc_pkg::quot_t t_c [3][OW+1];
	sdc_pkg::dvsr_t d_c [3][OW+1];

	for (genvar k = 0; k < 3; k++) begin : g_ch
		assign rem_c[k][0] = rem_s68[k];
		assign t_c[k][0]   = t_s68[k];
		assign d_c[k][0]   = d_s68[k];
		for (genvar j = 0; j < OW; j++) begin : g_div
			sdc_div_cell u_div (
				.clk   (clk), .en (en),
				.rem_i (rem_c[k][j]), .t_i (t_c[k][j]), .d_i (d_c[k][j]),
				.rem_o (rem_c[k][j+1]), .t_o (t_c[k][j+1]), .d_o (d_c[k][j+1])
			);
		end
	end

	logic [4:0]     fl_end;
	sdc_pkg::quot_t res [3];
	logic           sat_any;

	sdc_delay #(.W(5), .DEPTH(OW)) u_end_dly (
		.clk (clk), .en (en), .d ({sat_s68, sph_s68, inv_s68}), .q (fl_end)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			res[k] = fl_end[0] ? '0 : (fl_end[2+k] ? sdc_pkg::OUT_MAX : t_c[k][OW]);
		end
		sat_any = !fl_end[0] && (fl_end[4:2] != 3'b000);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (!m_tvalid_q || m_tready) begin
			m_tvalid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid_q || m_tready) begin
			m_tdata_q <= {res[2], res[1], res[0]};
			m_tuser_q <= {fl_end[0], sat_any, fl_end[1] && !fl_end[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`SDC_ASSERT(a_inv_zero, m_tvalid_q && m_tuser_q[2], (m_tdata_q == '0) && (m_tuser_q[1:0] == 2'b00), "invalid request gave non-zero result")
	`SDC_ASSERT(a_sat_max, m_tvalid_q && m_tuser_q[1], (m_tdata_q[OW-1:0] == sdc_pkg::OUT_MAX) || (m_tdata_q[2*OW-1:OW] == sdc_pkg::OUT_MAX) || (m_tdata_q[3*OW-1:2*OW] == sdc_pkg::OUT_MAX), "saturated flag without clipped output")
	`SDC_ASSERT(a_sph_equal, m_tvalid_q && m_tuser_q[0], m_tdata_q[OW-1:0] == m_tdata_q[2*OW-1:OW], "sphere translations differ")
	`SDC_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved while stalled")
endmodule

// ----- rtl/sdc_delay.sv -----
`timescale 1ns / 1ps
module sdc_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];
endmodule

// ----- rtl/sdc_mul.sv -----
`timescale 1ns / 1ps
module sdc_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [WA-1:0]      a,
	input  logic [WB-1:0]      b,
	output logic [WA+WB-1:0]   p
);
	localparam int LA = (WA + 31) / 32;
	localparam int LB = (WB + 31) / 32;
	localparam int PW = (LA + LB) * 32;

	logic [LA*32-1:0] a_x;
	logic [LB*32-1:0] b_x;
	logic [63:0]      pp_s1 [LA*LB];
	logic [PW-1:0]    acc;
	logic [PW-1:0]    p_s2;

	assign a_x = (LA*32)'(a);
	assign b_x = (LB*32)'(b);

	// 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LA; i++) begin
				for (int j = 0; j < LB; j++) begin
					pp_s1[i*LB+j] <= 64'(a_x[32*i +: 32]) * 64'(b_x[32*j +: 32]);
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < LA; i++) begin
			for (int j = 0; j < LB; j++) begin
				acc = acc + (PW'(pp_s1[i*LB+j]) << (32*(i+j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc;
		end
	end

	assign p = p_s2[WA+WB-1:0];
endmodule

// ----- rtl/sdc_log_cell.sv -----
`timescale 1ns / 1ps
module sdc_log_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [63:0]                     m_i,
	input  logic [sdc_pkg::LOG_STEPS-1:0]   f_i,
	output logic [63:0]                     m_o,
	output logic [sdc_pkg::LOG_STEPS-1:0]   f_o
);
	logic [63:0]                   p00_s1;
	logic [63:0]                   p01_s1;
	logic [63:0]                   p11_s1;
	logic [sdc_pkg::LOG_STEPS-1:0] f_s1;
	logic [127:0]                  sq;
	logic [63:0]                   mn;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(m_i[31:0]) * 64'(m_i[31:0]);
			p01_s1 <= 64'(m_i[31:0]) * 64'(m_i[63:32]);
			p11_s1 <= 64'(m_i[63:32]) * 64'(m_i[63:32]);
			f_s1   <= f_i;
		end
	end

	// square of Q1.62 mantissa, cross term counted twice
	always_comb begin
		sq = {p11_s1, 64'd0} + {31'd0, p01_s1, 33'd0} + {64'd0, p00_s1};
		mn = sq[125:62];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_o <= mn[63] ? {1'b0, mn[63:1]} : mn;
			f_o <= {f_s1[sdc_pkg::LOG_STEPS-2:0], mn[63]};
		end
	end
endmodule

// ----- rtl/sdc_div_cell.sv -----
`timescale 1ns / 1ps
module sdc_div_cell (
	input  logic           clk,
	input  logic           en,
	input  sdc_pkg::dvsr_t rem_i,
	input  sdc_pkg::quot_t t_i,
	input  sdc_pkg::dvsr_t d_i,
	output sdc_pkg::dvsr_t rem_o,
	output sdc_pkg::quot_t t_o,
	output sdc_pkg::dvsr_t d_o
);
	logic [sdc_pkg::D_W:0] sh;
	logic [sdc_pkg::D_W:0] df;
	logic                  ge;

	always_comb begin
		sh = {rem_i, t_i[sdc_pkg::OUT_W-1]};
		ge = sh >= {1'b0, d_i};
		df = sh - {1'b0, d_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? df[sdc_pkg::D_W-1:0] : sh[sdc_pkg::D_W-1:0];
			t_o   <= {t_i[sdc_pkg::OUT_W-2:0], ge};
			d_o   <= d_i;
		end
	end
endmodule
